// ===== hw/rtl/ntxb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntxb_pkg
// Shared types, constants and character helpers for the nonce/XOR/Base64
// codec: mask table, Base64 alphabet mapping, result bundle layout.
// ----------------------------------------------------------------------------
package ntxb_pkg;

  localparam int TABLE_SIZE = 256;

  // Mask table, entry 0 in the top byte.
  localparam logic [8*TABLE_SIZE-1:0] MASK_ROM = {
    "welcome R", "ising*youarelawless!y2a",
    "3n4g5Y6U7q8i@S9I0N#A.C%O(M-)<>AB",
    "I993JIEM,;'{jkliewaqlsiqomv.z^iw",
    "aql}-_=+)_(l;2j2f90aslkjflkasjas",
    "32092JKLSJFbASAUI/Z/A[/,./|@~", 8'h60, "FS",
    "'.Z,MF920SDLAFJKAL9320QFFMmlajfl",
    ",.<>//|348q9729|fjlail3jo798,ksa",
    "fa302-s;akfa;=_++-0-_))0-0-p23is"
  };

  // Character codes
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_DASH    = 8'h2D;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_PAD     = 8'h3D;

  // Register word index (paddr[2])
  localparam logic REG_IDX_DIRECTION = 1'b0;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_MISMATCH = 2'd1,
    STATUS_SHORT    = 2'd2
  } status_t;

  // Four Base64 characters, [0] goes out first.
  typedef logic [3:0][7:0] quad_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } sextet_t;

  // All results caused by one input transaction.
  typedef struct packed {
    logic [7:0][7:0] chars;        // [0] goes out first
    logic [2:0]      last_rec;     // index of final record
    logic            msg_last;     // final record closes the message
    logic            tail_status;  // final record is status only
    status_t         status;       // status of final record
  } bundle_t;

  function automatic logic [7:0] mask_key(input logic [7:0] idx);
    return MASK_ROM[8*(TABLE_SIZE-1-int'(idx)) +: 8];
  endfunction

  // Sextet to character, '+' sent as '-'.
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = CHAR_UPPER_A + {2'b00, v};
    end else if (v < 6'd52) begin
      c = CHAR_LOWER_A + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = CHAR_DIGIT_0 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = CHAR_DASH;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

  function automatic sextet_t char_value(input logic [7:0] c);
    sextet_t r;
    r.ok    = 1'b1;
    r.value = '0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r.value = 6'(c - CHAR_UPPER_A);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      r.value = 6'(c - CHAR_LOWER_A + 8'd26);
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      r.value = 6'(c - CHAR_DIGIT_0 + 8'd52);
    end else if (c == CHAR_PLUS || c == CHAR_DASH) begin
      r.value = 6'd62;
    end else if (c == CHAR_SLASH) begin
      r.value = 6'd63;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // 24-bit group to four characters; npad trailing characters (at most two) become '='.
  function automatic quad_t b64_quad(input logic [23:0] v, input logic [1:0] npad);
    quad_t q;
    q[0] = b64_char(v[23:18]);
    q[1] = b64_char(v[17:12]);
    q[2] = (npad >= 2'd2) ? CHAR_PAD : b64_char(v[11:6]);
    q[3] = (npad != 2'd0) ? CHAR_PAD : b64_char(v[5:0]);
    return q;
  endfunction

endpackage

// ===== hw/rtl/ntxb_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntxb_emit
// Result buffer: one bundle slot plus a serializer that sends the records
// of a bundle one per transaction on the output channel.
// ----------------------------------------------------------------------------
module ntxb_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ntxb_pkg::bundle_t push_data,
  output logic              slot_ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_valid_byte,
  output logic              out_last,
  output logic [1:0]        status
);

  logic              slot_valid;
  ntxb_pkg::bundle_t slot;
  logic              cur_valid;
  ntxb_pkg::bundle_t cur;
  logic [2:0]        idx;

  logic take;
  logic cur_final;
  logic cur_done;
  logic cur_load;
  logic tail_rec;

  assign take       = cur_valid && !out_stall;
  assign cur_final  = (idx == cur.last_rec);
  assign cur_done   = take && cur_final;
  assign cur_load   = slot_valid && (!cur_valid || cur_done);
  assign slot_ready = !slot_valid || cur_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      cur_valid  <= 1'b0;
      idx        <= '0;
    end else begin
      if (push) begin
        slot_valid <= 1'b1;
      end else if (cur_load) begin
        slot_valid <= 1'b0;
      end
      if (cur_load) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (cur_done) begin
        cur_valid <= 1'b0;
      end else if (take) begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot <= push_data;
    end
    if (cur_load) begin
      cur <= slot;
    end
  end

  assign tail_rec       = cur_final && cur.tail_status;
  assign out_valid      = cur_valid;
  assign out_byte       = tail_rec ? 8'h00 : cur.chars[idx];
  assign out_valid_byte = !tail_rec;
  assign out_last       = cur_final && cur.msg_last;
  assign status         = cur_final ? cur.status : ntxb_pkg::STATUS_OK;

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> slot_ready)
    else $error("bundle pushed into a full slot");

  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> idx <= cur.last_rec)
    else $error("record index past end of bundle");

  a_slot_promotes: assert property (@(posedge clk) disable iff (rst)
    slot_valid && !cur_valid |=> cur_valid)
    else $error("waiting bundle not moved to serializer");

endmodule

// ===== hw/rtl/nonce_table_xor_base64_codec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonce_table_xor_base64_codec
// Streaming nonce-keyed XOR codec with Base64 transport ('-' in place of '+'), encode or decode.
// ----------------------------------------------------------------------------
// Path: input register, then result slot, then serializer, which drives the output.
// Throughput: one input transaction per cycle while each yields at most one
//   result and the output does not stall. Results leave one per cycle, unless
//   the output stalls, from a serializer with a one-bundle slot in front of
//   it, so the input stalls only while both hold bundles (a bundle holds 4
//   records for a closed group, up to 8 at the end of a message).
// Reset: synchronous; direction returns to encode and the message counters,
//   sum, group and flags clear at once (not the nonce ring or held byte). No clearing pass.
// ----------------------------------------------------------------------------
module nonce_table_xor_base64_codec #(
  parameter int NONCE_LEN = 6
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_valid_byte,
  output logic        out_last,
  output logic [1:0]  status
);

  localparam int HC_W     = $clog2(NONCE_LEN + 1);
  localparam int KEY2_IDX = (NONCE_LEN > 1) ? 1 : 0;
  localparam logic [HC_W-1:0] HC_FULL = HC_W'(NONCE_LEN);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  ntxb_pkg::dir_t direction;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == ntxb_pkg::REG_IDX_DIRECTION);

  always_comb begin
    prdata = '0;
    if (paddr[2] == ntxb_pkg::REG_IDX_DIRECTION) begin
      prdata[0] = direction;
    end
  end

  // --------------------------------------------------------------------------
  // Input register. The item waits here until the result slot has room.
  // --------------------------------------------------------------------------
  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       in_q_last;
  logic       slot_ready;
  logic       step;
  logic       accept;

  assign in_stall = in_q_valid && !slot_ready;
  assign accept   = in_valid && !in_stall;
  assign step     = in_q_valid && slot_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (accept) begin
      in_q_valid <= 1'b1;
    end else if (step) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q_byte <= in_byte;
      in_q_last <= in_last;
    end
  end

  // --------------------------------------------------------------------------
  // Message state
  // The nonce is held as a ring: ring[0] is always the byte that picks the
  // next mask, so the key pointer becomes a rotation. Header bytes shift in
  // at the top; after the full nonce ring[0] holds the first nonce byte.
  // --------------------------------------------------------------------------
  logic [7:0]      ring [NONCE_LEN];
  logic [HC_W-1:0] hc;         // header bytes seen
  logic [7:0]      sum;        // running mod-256 plaintext sum
  logic [15:0]     grp;        // pending group bits
  logic [2:0]      fill;       // encode: bytes pending, decode: bits pending
  logic [7:0]      held_byte;  // decode: plaintext held back one byte
  logic            held_valid;
  logic            body_seen;  // decode: a plaintext byte went out

  logic [7:0]      ring_next [NONCE_LEN];
  logic [HC_W-1:0] hc_next;
  logic [7:0]      sum_next;
  logic [15:0]     grp_next;
  logic [2:0]      fill_next;
  logic [7:0]      held_byte_next;
  logic            held_valid_next;
  logic            body_next;

  logic [7:0] ring_rot [NONCE_LEN];
  logic [7:0] ring_shift [NONCE_LEN];
  logic [7:0] shift_in;

  // datapath nets
  logic              hdr;
  logic [7:0]        key1;
  logic [7:0]        key2;
  logic [7:0]        enc_x;
  logic [7:0]        sum_add;
  logic [1:0]        enc_f;
  logic [1:0]        enc_f1;
  logic [15:0]       grp1;
  logic [7:0]        chk;
  ntxb_pkg::quad_t   quad_a;
  ntxb_pkg::quad_t   quad_b;
  ntxb_pkg::sextet_t sx;
  logic [11:0]       dec_gx;
  logic              dec_have;
  logic [2:0]        dec_shift;
  logic [7:0]        dec_d;
  logic [7:0]        dec_p;
  logic              dec_emit;
  logic [3:0]        n_recs;
  ntxb_pkg::bundle_t bnd;
  logic              push;

  assign hdr  = (hc < HC_FULL);
  assign key1 = ntxb_pkg::mask_key(ring[0]);
  assign key2 = ntxb_pkg::mask_key(ring[KEY2_IDX]);

  // Encode side. First push: nonce byte as is, payload byte masked.
  // Group A closes when two bytes were already pending.
  assign enc_x   = hdr ? in_q_byte : (in_q_byte ^ key1);
  assign sum_add = sum + in_q_byte;
  assign enc_f   = fill[1:0];
  assign quad_a  = ntxb_pkg::b64_quad({grp, enc_x}, 2'd0);
  assign grp1    = (enc_f == 2'd2) ? 16'h0000 : {grp[7:0], enc_x};
  assign enc_f1  = (enc_f == 2'd2) ? 2'd0 : (enc_f + 2'd1);
  // Masked checksum uses the next nonce byte in the rotation.
  assign chk     = sum_add ^ key2;

  // Group B at message end: either the checksum closes a full group or the
  // flush emits a padded one. Exactly four characters in every case.
  always_comb begin
    case (enc_f1)
      2'd2:    quad_b = ntxb_pkg::b64_quad({grp1, chk}, 2'd0);
      2'd1:    quad_b = ntxb_pkg::b64_quad({grp1[7:0], chk, 8'h00}, 2'd1);
      default: quad_b = ntxb_pkg::b64_quad({chk, 16'h0000}, 2'd2);
    endcase
  end

  // Decode side. Pending bits stay below 2^fill, so 12 bits cover the
  // group after a new sextet; a byte is ready once 8 bits are present.
  assign sx        = ntxb_pkg::char_value(in_q_byte);
  assign dec_gx    = {grp[5:0], sx.value};
  assign dec_have  = sx.ok && (fill >= 3'd2);
  assign dec_shift = fill - 3'd2;
  assign dec_d     = 8'(dec_gx >> dec_shift);
  assign dec_p     = dec_d ^ key1;

  assign shift_in = (direction == ntxb_pkg::DIR_DECODE) ? dec_d : in_q_byte;

  always_comb begin
    for (int i = 0; i < NONCE_LEN - 1; i++) begin
      ring_rot[i]   = ring[i+1];
      ring_shift[i] = ring[i+1];
    end
    ring_rot[NONCE_LEN-1]   = ring[0];
    ring_shift[NONCE_LEN-1] = shift_in;
  end

  always_comb begin
    ring_next       = ring;
    hc_next         = hc;
    sum_next        = sum;
    grp_next        = grp;
    fill_next       = fill;
    held_byte_next  = held_byte;
    held_valid_next = held_valid;
    body_next       = body_seen;
    dec_emit        = 1'b0;
    n_recs          = 4'd0;
    bnd             = '0;

    if (step) begin
      if (direction == ntxb_pkg::DIR_ENCODE) begin
        if (hdr) begin
          ring_next = ring_shift;
          hc_next   = hc + 1'b1;
        end else begin
          ring_next = ring_rot;
          sum_next  = sum_add;
          body_next = 1'b1;
        end
        grp_next  = grp1;
        fill_next = {1'b0, enc_f1};

        bnd.chars[3:0] = (enc_f == 2'd2) ? quad_a : quad_b;
        bnd.chars[7:4] = quad_b;
        if (enc_f == 2'd2) begin
          n_recs = 4'd4;
        end
        if (in_q_last) begin
          // end during the header (including on its last byte): status only
          n_recs          = n_recs + (hdr ? 4'd1 : 4'd4);
          bnd.tail_status = hdr;
          bnd.status      = hdr ? ntxb_pkg::STATUS_SHORT : ntxb_pkg::STATUS_OK;
        end
      end else begin
        if (sx.ok) begin
          if (dec_have) begin
            grp_next  = {4'b0000, dec_gx & ~(12'hFFF << dec_shift)};
            fill_next = dec_shift;
            if (hdr) begin
              ring_next = ring_shift;
              hc_next   = hc + 1'b1;
            end else begin
              ring_next = ring_rot;
              if (held_valid) begin
                dec_emit  = 1'b1;
                sum_next  = sum + held_byte;
                body_next = 1'b1;
              end
              held_byte_next  = dec_p;
              held_valid_next = 1'b1;
            end
          end else begin
            grp_next  = {4'b0000, dec_gx};
            fill_next = fill + 3'd6;
          end
        end

        bnd.chars[0] = held_byte;
        if (dec_emit) begin
          n_recs = 4'd1;
        end
        if (in_q_last) begin
          // last byte held back is the checksum
          n_recs          = n_recs + 4'd1;
          bnd.tail_status = 1'b1;
          if (hc_next >= HC_FULL && body_next && held_valid_next) begin
            bnd.status = (held_byte_next == sum_next) ? ntxb_pkg::STATUS_OK
                                                      : ntxb_pkg::STATUS_MISMATCH;
          end else begin
            bnd.status = ntxb_pkg::STATUS_SHORT;
          end
        end
      end

      bnd.msg_last = in_q_last;
      if (in_q_last) begin
        hc_next         = '0;
        sum_next        = '0;
        grp_next        = '0;
        fill_next       = '0;
        held_valid_next = 1'b0;
        body_next       = 1'b0;
      end
    end

    bnd.last_rec = 3'(n_recs - 4'd1);
  end

  assign push = step && (n_recs != 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= ntxb_pkg::DIR_ENCODE;
      hc         <= '0;
      sum        <= '0;
      grp        <= '0;
      fill       <= '0;
      held_valid <= 1'b0;
      body_seen  <= 1'b0;
    end else if (cfg_wr) begin
      // a direction write also starts a fresh message
      direction  <= ntxb_pkg::dir_t'(pwdata[0]);
      hc         <= '0;
      sum        <= '0;
      grp        <= '0;
      fill       <= '0;
      held_valid <= 1'b0;
      body_seen  <= 1'b0;
    end else begin
      hc         <= hc_next;
      sum        <= sum_next;
      grp        <= grp_next;
      fill       <= fill_next;
      held_valid <= held_valid_next;
      body_seen  <= body_next;
    end
  end

  // nonce ring and held byte are only read once written in the message
  always_ff @(posedge clk) begin
    ring      <= ring_next;
    held_byte <= held_byte_next;
  end

  // --------------------------------------------------------------------------
  // Result slot and serializer
  // --------------------------------------------------------------------------
  ntxb_emit u_emit (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .push_data      (bnd),
    .slot_ready     (slot_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_valid_byte (out_valid_byte),
    .out_last       (out_last),
    .status         (status)
  );

  a_msg_end_clears: assert property (@(posedge clk) disable iff (rst)
    step && in_q_last |=> hc == '0 && fill == '0 && !held_valid && sum == '0)
    else $error("message state not cleared after last transaction");

  a_enc_fill: assert property (@(posedge clk) disable iff (rst)
    direction == ntxb_pkg::DIR_ENCODE |-> fill <= 3'd2)
    else $error("encode group holds more than two bytes");

  a_dec_fill: assert property (@(posedge clk) disable iff (rst)
    direction == ntxb_pkg::DIR_DECODE |-> !fill[0] && fill <= 3'd6)
    else $error("decode bit count out of step");

  a_status_only_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_valid_byte |-> out_last && out_byte == 8'h00)
    else $error("status-only result not at message end");

endmodule

// ===== tb/codec_stream_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// codec_stream_checker
// Watches the config port and both streams of the nonce/XOR/Base64 codec,
// predicts every result of each accepted input transaction and compares
// the results in order, field by field.
// ----------------------------------------------------------------------------
module codec_stream_checker #(
  parameter int NONCE_LEN = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_valid_byte,
  input  logic        out_last,
  input  logic [1:0]  status,
  output int          fault_count,
  output int          results_owed
);
  import ntxb_pkg::*;

  localparam logic [2:0] DIRECTION_ADDR = {REG_IDX_DIRECTION, 2'b00};

  // XOR key table, entry 0 in the top byte
  localparam logic [8*256-1:0] XOR_KEY_TABLE = {
    "welcome R", "ising*youarelawless!y2a",
    "3n4g5Y6U7q8i@S9I0N#A.C%O(M-)<>AB",
    "I993JIEM,;'{jkliewaqlsiqomv.z^iw",
    "aql}-_=+)_(l;2j2f90aslkjflkasjas",
    "32092JKLSJFbASAUI/Z/A[/,./|@~", 8'h60, "FS",
    "'.Z,MF920SDLAFJKAL9320QFFMmlajfl",
    ",.<>//|348q9729|fjlail3jo798,ksa",
    "fa302-s;akfa;=_++-0-_))0-0-p23is"
  };

  // transport alphabet; value 62 goes out as '-'
  localparam logic [8*64-1:0] SEXTET_CHARS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-/";

  typedef struct packed {
    logic [7:0] data;
    logic       carries_byte;
    logic       closes_msg;
    status_t    verdict;
  } codec_result_t;

  codec_result_t awaited[$];

  dir_t        mode;
  logic [7:0]  nonce_bytes [NONCE_LEN];
  int unsigned nonce_seen;
  int unsigned key_sel;
  logic [7:0]  plain_sum;
  logic [23:0] bit_pool;
  int unsigned pool_fill;
  logic [7:0]  held_plain;
  logic        held_ok;
  logic        body_seen;

  function automatic void forget_message();
    foreach (nonce_bytes[i]) nonce_bytes[i] = '0;
    nonce_seen = 0;
    key_sel    = 0;
    plain_sum  = '0;
    bit_pool   = '0;
    pool_fill  = 0;
    held_plain = '0;
    held_ok    = 1'b0;
    body_seen  = 1'b0;
  endfunction

  function automatic void queue_result(input logic [7:0] data, input logic carries,
                                       input logic closes, input status_t verdict);
    codec_result_t r;
    r.data         = data;
    r.carries_byte = carries;
    r.closes_msg   = closes;
    r.verdict      = verdict;
    awaited.push_back(r);
  endfunction

  // key byte for the next body byte, nonce bytes taken in rotation
  function automatic logic [7:0] next_mask();
    logic [7:0] m;
    m = XOR_KEY_TABLE[8*(255 - int'(nonce_bytes[key_sel])) +: 8];
    key_sel = (key_sel + 1 == NONCE_LEN) ? 0 : key_sel + 1;
    return m;
  endfunction

  function automatic void send_sextet(input logic [5:0] v);
    queue_result(SEXTET_CHARS[8*(63 - int'(v)) +: 8], 1'b1, 1'b0, STATUS_OK);
  endfunction

  function automatic void pack_enc_byte(input logic [7:0] b);
    bit_pool = {bit_pool[15:0], b};
    pool_fill++;
    if (pool_fill == 3) begin
      send_sextet(bit_pool[23:18]);
      send_sextet(bit_pool[17:12]);
      send_sextet(bit_pool[11:6]);
      send_sextet(bit_pool[5:0]);
      bit_pool  = '0;
      pool_fill = 0;
    end
  endfunction

  function automatic void pad_enc_tail();
    logic [23:0] v;
    if (pool_fill != 0) begin
      v = (pool_fill == 1) ? {bit_pool[7:0], 16'h0000} : {bit_pool[15:0], 8'h00};
      send_sextet(v[23:18]);
      send_sextet(v[17:12]);
      if (pool_fill == 2) send_sextet(v[11:6]);
      else queue_result(CHAR_PAD, 1'b1, 1'b0, STATUS_OK);
      queue_result(CHAR_PAD, 1'b1, 1'b0, STATUS_OK);
      bit_pool  = '0;
      pool_fill = 0;
    end
  endfunction

  // {valid, value} of a text character
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = '0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) r = {1'b1, 6'(c - CHAR_UPPER_A)};
    else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) r = {1'b1, 6'(c - CHAR_LOWER_A + 8'd26)};
    else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) r = {1'b1, 6'(c - CHAR_DIGIT_0 + 8'd52)};
    else if (c == CHAR_PLUS || c == CHAR_DASH) r = {1'b1, 6'd62};
    else if (c == CHAR_SLASH) r = {1'b1, 6'd63};
    return r;
  endfunction

  // plaintext leaves one byte late: the newest byte may be the checksum
  function automatic void unpack_dec_byte(input logic [7:0] d);
    logic [7:0] p;
    if (nonce_seen < NONCE_LEN) begin
      nonce_bytes[nonce_seen] = d;
      nonce_seen++;
    end else begin
      p = d ^ next_mask();
      if (held_ok) begin
        queue_result(held_plain, 1'b1, 1'b0, STATUS_OK);
        plain_sum = plain_sum + held_plain;
        body_seen = 1'b1;
      end
      held_plain = p;
      held_ok    = 1'b1;
    end
  endfunction

  function automatic void predict_step(input logic [7:0] b, input logic closes);
    logic [6:0]    sx;
    codec_result_t tail;
    status_t       verdict;
    if (mode == DIR_ENCODE) begin
      if (nonce_seen < NONCE_LEN) begin
        nonce_bytes[nonce_seen] = b;
        nonce_seen++;
        pack_enc_byte(b);
      end else begin
        plain_sum = plain_sum + b;
        pack_enc_byte(b ^ next_mask());
        body_seen = 1'b1;
      end
      if (closes) begin
        if (nonce_seen >= NONCE_LEN && body_seen) begin
          pack_enc_byte(plain_sum ^ next_mask());
          pad_enc_tail();
          tail = awaited.pop_back();
          tail.closes_msg = 1'b1;
          awaited.push_back(tail);
        end else begin
          queue_result('0, 1'b0, 1'b1, STATUS_SHORT);
        end
        forget_message();
      end
    end else begin
      sx = sextet_of(b);
      if (sx[6]) begin
        bit_pool  = {bit_pool[17:0], sx[5:0]};
        pool_fill = pool_fill + 6;
        if (pool_fill >= 8) begin
          pool_fill = pool_fill - 8;
          unpack_dec_byte(8'(bit_pool >> pool_fill));
          bit_pool = bit_pool & ((24'd1 << pool_fill) - 24'd1);
        end
      end
      if (closes) begin
        if (nonce_seen >= NONCE_LEN && body_seen && held_ok)
          verdict = (held_plain == plain_sum) ? STATUS_OK : STATUS_MISMATCH;
        else
          verdict = STATUS_SHORT;
        queue_result('0, 1'b0, 1'b1, verdict);
        forget_message();
      end
    end
  endfunction

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h", $time, what, want, got);
      fault_count++;
    end
  endfunction

  always @(posedge clk) begin
    codec_result_t want;
    if (rst) begin
      mode = DIR_ENCODE;
      forget_message();
      awaited.delete();
    end else begin
      // results first: they always belong to older transactions
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual byte 0x%02h vb %0b last %0b st %0d",
                   $time, out_byte, out_valid_byte, out_last, status);
          fault_count++;
        end else begin
          want = awaited.pop_front();
          check_field("out_byte", want.data, out_byte);
          check_field("out_valid_byte", {7'b0, want.carries_byte}, {7'b0, out_valid_byte});
          check_field("out_last", {7'b0, want.closes_msg}, {7'b0, out_last});
          check_field("status", {6'b0, want.verdict}, {6'b0, status});
        end
      end
      if (psel && penable && pready && paddr == DIRECTION_ADDR) begin
        if (pwrite) begin
          mode = dir_t'(pwdata[0]);
          forget_message();
        end else if (prdata !== {31'b0, mode}) begin
          $display("%0t: direction readback mismatch, expected 0x%08h, actual 0x%08h",
                   $time, {31'b0, mode}, prdata);
          fault_count++;
        end
      end
      if (in_valid && !in_stall) predict_step(in_byte, in_last);
    end
    results_owed = awaited.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the nonce/XOR/Base64 codec. Encode phases send
// nonce+payload messages (plus short and abandoned ones); the text the block
// produces is captured and played back in the following decode phase, clean,
// with noise and '+' for '-', corrupted or cut short. Noise messages and
// random text fill in the rest. Results are checked by codec_stream_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import ntxb_pkg::*;

  localparam int         NONCE_BYTES    = 6;
  localparam logic [2:0] DIRECTION_ADDR = {REG_IDX_DIRECTION, 2'b00};
  localparam int         WATCHDOG_LIMIT = 2000;  // cycles with no transaction
  localparam int         DRAIN_PAUSE    = 8;
  localparam int         SETTLE_CYCLES  = 20;
  localparam int         TARGET_ITEMS   = 160;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_t;
  typedef enum {REPLAY_CLEAN, REPLAY_NOISY, REPLAY_CORRUPT, REPLAY_TRUNCATED} replay_kind_t;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte   = '0;
  logic        in_last   = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_valid_byte;
  logic        out_last;
  logic [1:0]  status;

  int fault_count;
  int results_owed;

  nonce_table_xor_base64_codec #(
    .NONCE_LEN(NONCE_BYTES)
  ) DUT (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .in_byte, .in_last,
    .out_valid, .out_stall, .out_byte, .out_valid_byte, .out_last, .status
  );

  codec_stream_checker #(
    .NONCE_LEN(NONCE_BYTES)
  ) stream_check (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .in_byte, .in_last,
    .out_valid, .out_stall, .out_byte, .out_valid_byte, .out_last, .status,
    .fault_count, .results_owed
  );

  // 2 ns clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // --------------------------------------------------------------------------
  // Receiver back-pressure: a mode is held for a stretch, then redrawn. One
  // mode never stalls, the others stall lightly, heavily or in long runs.
  // --------------------------------------------------------------------------
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          run_left   = 0;
  logic        run_level  = 1'b0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 120);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
      default: begin
        if (run_left == 0) begin
          run_left  = $urandom_range(1, 12);
          run_level = ~run_level;
        end
        run_left--;
        out_stall <= run_level;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Capture of encoded text. Every message the block closes with text is kept
  // so that the next decode phase can feed it back. Flat storage: characters
  // in one queue, start and length per message.
  // --------------------------------------------------------------------------
  dir_t       cur_dir = DIR_ENCODE;
  logic [7:0] text_acc[$];
  logic [7:0] lib_chars[$];
  int         lib_start[$];
  int         lib_len[$];

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall && cur_dir == DIR_ENCODE) begin
      if (out_valid_byte) text_acc.push_back(out_byte);
      if (out_last) begin
        // status-only close means the message was too short: nothing to keep
        if (out_valid_byte) begin
          lib_start.push_back(lib_chars.size());
          lib_len.push_back(text_acc.size());
          foreach (text_acc[i]) lib_chars.push_back(text_acc[i]);
        end
        text_acc.delete();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run if no transaction moves on either stream or the
  // config port for too long.
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. All tasks start and end at a falling edge.
  // --------------------------------------------------------------------------
  logic [7:0] msg_buf[$];
  int         burst_left = 0;
  int         items_sent = 0;

  // One config transaction (setup, access), then an idle step with psel low so that the
  // next access never re-raises psel in the step that lowered it.
  task automatic apb_access(input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= DIRECTION_ADDR;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Write then read back; upper data bits are junk the block must ignore.
  task automatic set_direction(input dir_t d);
    logic [31:0] data;
    data    = $urandom();
    data[0] = d;
    cur_dir = d;
    apb_access(1'b1, data);
    apb_access(1'b0, '0);
  endtask

  // Sender works in bursts; between bursts valid usually drops for a random gap.
  task automatic send_item(input logic [7:0] b, input logic closes);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= closes;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // closes = 0 leaves the message open (abandoned by the next config write)
  task automatic send_buf(input logic closes);
    for (int i = 0; i < msg_buf.size(); i++)
      send_item(msg_buf[i], closes && (i == msg_buf.size() - 1));
  endtask

  // Hold the sender until every predicted result is out, then pause so that
  // transactions that produce nothing also finish in the block.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_PAUSE) @(negedge clk);
  endtask

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0:       c = CHAR_PAD;
      1:       c = CHAR_SPACE;
      2:       c = CHAR_NEWLINE;
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  // mostly alphabet characters, some arbitrary bytes
  function automatic logic [7:0] any_char();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0:       c = 8'($urandom_range(0, 255));
      1:       c = CHAR_UPPER_A + 8'($urandom_range(0, 25));
      2:       c = CHAR_LOWER_A + 8'($urandom_range(0, 25));
      3:       c = CHAR_DIGIT_0 + 8'($urandom_range(0, 9));
      4:       c = CHAR_SLASH;
      default: c = CHAR_DASH;
    endcase
    return c;
  endfunction

  // Encode message: usually nonce + short payload, sometimes long, sometimes
  // closed inside the nonce or right on its last byte (too short).
  task automatic build_plain_msg();
    int pick, len;
    pick = $urandom_range(0, 9);
    if (pick == 0) len = $urandom_range(1, NONCE_BYTES);
    else if (pick == 9) len = NONCE_BYTES + $urandom_range(16, 40);
    else len = NONCE_BYTES + $urandom_range(1, 9);
    msg_buf.delete();
    repeat (len) msg_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_noise_msg(input int max_len);
    msg_buf.delete();
    repeat ($urandom_range(1, max_len)) msg_buf.push_back(any_char());
  endtask

  function automatic replay_kind_t pick_replay();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return REPLAY_CLEAN;
    if (r < 7) return REPLAY_NOISY;
    if (r < 9) return REPLAY_CORRUPT;
    return REPLAY_TRUNCATED;
  endfunction

  // Captured text number idx, possibly altered. A corrupted character mostly
  // breaks the checksum; a cut text loses at least its last character, often the checksum.
  task automatic build_replay(input int idx, input replay_kind_t kind);
    int         base, cut, bad;
    logic [7:0] c;
    msg_buf.delete();
    if (idx < lib_len.size()) begin
      base = lib_start[idx];
      cut  = (kind == REPLAY_TRUNCATED) ? $urandom_range(1, lib_len[idx] - 1) : lib_len[idx];
      bad  = (kind == REPLAY_CORRUPT) ? $urandom_range(0, lib_len[idx] - 1) : -1;
      for (int i = 0; i < cut; i++) begin
        c = lib_chars[base + i];
        if (i == bad) c = CHAR_LOWER_A + 8'($urandom_range(0, 25));
        if (kind == REPLAY_NOISY) begin
          // decoder accepts both spellings of 62 and skips non-alphabet bytes
          if (c == CHAR_DASH && $urandom_range(0, 1) == 1) c = CHAR_PLUS;
          if ($urandom_range(0, 5) == 0) msg_buf.push_back(noise_char());
        end
        msg_buf.push_back(c);
      end
    end
  endtask

  function automatic void forget_captures();
    text_acc.delete();
    lib_chars.delete();
    lib_start.delete();
    lib_len.delete();
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed encode ----
    set_direction(DIR_ENCODE);
    // extreme nonce and payload values; 10 bytes with checksum -> "==" tail
    msg_buf = {8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'hFF, 8'h00, 8'h81};
    send_buf(1'b1);
    // closed inside the nonce
    msg_buf = {8'h5A, 8'hA5};
    send_buf(1'b1);
    // closed on the last nonce byte: no payload, still too short
    msg_buf = {8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h33, 8'hCC};
    send_buf(1'b1);
    // one payload byte -> single '=' tail
    msg_buf = {8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60, 8'hC3};
    send_buf(1'b1);
    // one-transaction message
    msg_buf = {8'h42};
    send_buf(1'b1);
    // left open; the direction write below must discard it
    msg_buf = {8'h01, 8'h02, 8'h03};
    send_buf(1'b0);
    drain_results();

    // ---- directed decode ----
    set_direction(DIR_DECODE);
    build_replay(0, REPLAY_CLEAN);
    send_buf(1'b1);
    build_replay(1, REPLAY_NOISY);
    send_buf(1'b1);
    // only skipped characters plus a lone '+': too short
    msg_buf = {8'h00, 8'hFF, CHAR_PLUS, CHAR_PAD};
    send_buf(1'b1);
    drain_results();

    // ---- random rounds: encode phase, then decode of what it produced ----
    while (items_sent < TARGET_ITEMS) begin
      set_direction(DIR_ENCODE);
      forget_captures();
      repeat ($urandom_range(3, 4)) begin
        build_plain_msg();
        send_buf(1'b1);
      end
      if ($urandom_range(0, 1) == 1) begin
        build_noise_msg(5);
        send_buf(1'b0);
      end
      drain_results();

      set_direction(DIR_DECODE);
      for (int i = 0; i < lib_len.size(); i++) begin
        build_replay(i, pick_replay());
        send_buf(1'b1);
      end
      repeat ($urandom_range(1, 2)) begin
        build_noise_msg(40);
        send_buf(1'b1);
      end
      if ($urandom_range(0, 1) == 1) begin
        build_noise_msg(8);
        send_buf(1'b0);
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fault_count == 0 && results_owed == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ntxb_pkg.sv
hw/rtl/ntxb_emit.sv
hw/rtl/nonce_table_xor_base64_codec.sv
tb/codec_stream_checker.sv
tb/tb_top.sv
